FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; every rtl file refers to it by scoped names.
package lkv_pkg;

    // Parameter defaults
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 64;
    localparam int DIN_W     = 32;
    localparam int STAMP_W   = 64;
    localparam int CFG_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int TOTAL_W   = 32;

    // Stream packing
    localparam int S_TDATA_W = KEY_W + DIN_W;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_FIELD_W = DIN_W + 2 * CNT_OUT_W + 2 * TOTAL_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W = 1;

    // max_entries after reset
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_TRIM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM_CHK,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Valid-bit update request toward the entry store
    typedef struct packed {
        logic set;
        logic drop;
        logic clear_all;
    } vld_op_t;

    // Flags left by one full scan of the entries
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic old_found;
    } scan_res_t;

endpackage

FILE: rtl/lkv_store.sv
// Entry store: key/data/stamp memory with registered read, plus valid bits.
// Depends on lkv_pkg.
module lkv_store #(
    parameter int CAPACITY    = lkv_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF,
    localparam int IDXW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [IDXW-1:0]                   rd_idx,
    output logic [lkv_pkg::KEY_W-1:0]         rd_key,
    output logic [VALUE_WIDTH-1:0]            rd_data,
    output logic [lkv_pkg::STAMP_W-1:0]       rd_stamp,
    input  logic                              wr_en,
    input  logic [IDXW-1:0]                   wr_idx,
    input  logic [lkv_pkg::KEY_W-1:0]         wr_key,
    input  logic [VALUE_WIDTH-1:0]            wr_data,
    input  logic [lkv_pkg::STAMP_W-1:0]       wr_stamp,
    input  lkv_pkg::vld_op_t                  vop,
    input  logic [IDXW-1:0]                   drop_idx,
    output logic [CAPACITY-1:0]               valid
);
    localparam int MW   = lkv_pkg::KEY_W + VALUE_WIDTH + lkv_pkg::STAMP_W;

    logic [MW-1:0]       mem [CAPACITY];
    logic [MW-1:0]       rdata_reg;
    logic [CAPACITY-1:0] valid_reg;

    // Write one entry, read one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_stamp, wr_data, wr_key};
        end
        rdata_reg <= mem[rd_idx];
    end

    assign rd_key   = rdata_reg[lkv_pkg::KEY_W-1:0];
    assign rd_data  = rdata_reg[lkv_pkg::KEY_W +: VALUE_WIDTH];
    assign rd_stamp = rdata_reg[MW-1 -: lkv_pkg::STAMP_W];

    // Valid bits: drop before set, so a refill of the evicted slot stays valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (vop.clear_all) begin
            valid_reg <= '0;
        end else begin
            if (vop.drop) begin
                valid_reg[drop_idx] <= 1'b0;
            end
            if (vop.set) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign valid = valid_reg;

endmodule

FILE: rtl/lkv_scan.sv
// Scan unit: walks all entries one per cycle with a shared key and stamp compare.
// Finds first key match, first free slot and oldest valid entry. Depends on lkv_pkg.
module lkv_scan #(
    parameter int CAPACITY    = lkv_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF,
    localparam int IDXW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [lkv_pkg::KEY_W-1:0]         key,
    input  logic [CAPACITY-1:0]               valid,
    output logic [IDXW-1:0]                   rd_idx,
    input  logic [lkv_pkg::KEY_W-1:0]         rd_key,
    input  logic [VALUE_WIDTH-1:0]            rd_data,
    input  logic [lkv_pkg::STAMP_W-1:0]       rd_stamp,
    output logic                              done,
    output lkv_pkg::scan_res_t                res,
    output logic [IDXW-1:0]                   match_idx,
    output logic [VALUE_WIDTH-1:0]            match_data,
    output logic [IDXW-1:0]                   free_idx,
    output logic [IDXW-1:0]                   old_idx
);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

    logic                        issue_reg, issue_next;
    logic [IDXW-1:0]             issue_idx_reg, issue_idx_next;
    logic                        chk_vld_reg, chk_vld_next;
    logic [IDXW-1:0]             chk_idx_reg, chk_idx_next;
    logic                        done_reg, done_next;
    lkv_pkg::scan_res_t          res_reg, res_next;
    logic [IDXW-1:0]             match_idx_reg, match_idx_next;
    logic [VALUE_WIDTH-1:0]      match_data_reg, match_data_next;
    logic [IDXW-1:0]             free_idx_reg, free_idx_next;
    logic [IDXW-1:0]             old_idx_reg, old_idx_next;
    logic [lkv_pkg::STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic                        chk_valid;
    logic                        key_eq;
    logic                        stamp_lt;

    // Shared compare unit
    assign chk_valid = valid[chk_idx_reg];
    assign key_eq    = (rd_key == key);
    assign stamp_lt  = (rd_stamp < old_stamp_reg);

    always_comb begin
        issue_next      = issue_reg;
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = issue_reg;
        chk_idx_next    = issue_idx_reg;
        done_next       = chk_vld_reg && (chk_idx_reg == LAST_IDX);
        res_next        = res_reg;
        match_idx_next  = match_idx_reg;
        match_data_next = match_data_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        old_stamp_next  = old_stamp_reg;

        // Advance the read address
        if (start) begin
            issue_next     = 1'b1;
            issue_idx_next = '0;
            res_next       = '0;
        end else begin
            if (issue_reg) begin
                if (issue_idx_reg == LAST_IDX) begin
                    issue_next = 1'b0;
                end else begin
                    issue_idx_next = issue_idx_reg + IDXW'(1);
                end
            end
            // Fold the entry read last cycle into the trackers
            if (chk_vld_reg) begin
                if (chk_valid && key_eq && !res_reg.match_found) begin
                    res_next.match_found = 1'b1;
                    match_idx_next       = chk_idx_reg;
                    match_data_next      = rd_data;
                end
                if (!chk_valid && !res_reg.free_found) begin
                    res_next.free_found = 1'b1;
                    free_idx_next       = chk_idx_reg;
                end
                if (chk_valid && (!res_reg.old_found || stamp_lt)) begin
                    res_next.old_found = 1'b1;
                    old_idx_next       = chk_idx_reg;
                    old_stamp_next     = rd_stamp;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            res_reg     <= '0;
        end else begin
            issue_reg   <= issue_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        match_idx_reg  <= match_idx_next;
        match_data_reg <= match_data_next;
        free_idx_reg   <= free_idx_next;
        old_idx_reg    <= old_idx_next;
        old_stamp_reg  <= old_stamp_next;
    end

    assign rd_idx     = issue_idx_reg;
    assign done       = done_reg;
    assign res        = res_reg;
    assign match_idx  = match_idx_reg;
    assign match_data = match_data_reg;
    assign free_idx   = free_idx_reg;
    assign old_idx    = old_idx_reg;

endmodule

FILE: rtl/lkv_seq.sv
// Sequencer: runs put/get/trim over the scan unit and clear directly, keeps counters and stamps,
// and holds the result beat. Depends on lkv_pkg.
module lkv_seq #(
    parameter int CAPACITY    = lkv_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF,
    localparam int IDXW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beat
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  lkv_pkg::kind_t                     in_kind,
    input  logic [lkv_pkg::KEY_W-1:0]          in_key,
    input  logic [lkv_pkg::DIN_W-1:0]          in_data,
    input  logic [lkv_pkg::CFG_W-1:0]          max_entries,
    // scan unit
    output logic                               scan_start,
    output logic [lkv_pkg::KEY_W-1:0]          scan_key,
    input  logic                               scan_done,
    input  lkv_pkg::scan_res_t                 scan_res,
    input  logic [IDXW-1:0]                    match_idx,
    input  logic [VALUE_WIDTH-1:0]             match_data,
    input  logic [IDXW-1:0]                    free_idx,
    input  logic [IDXW-1:0]                    old_idx,
    // entry store
    output logic                               wr_en,
    output logic [IDXW-1:0]                    wr_idx,
    output logic [lkv_pkg::KEY_W-1:0]          wr_key,
    output logic [VALUE_WIDTH-1:0]             wr_data,
    output logic [lkv_pkg::STAMP_W-1:0]        wr_stamp,
    output lkv_pkg::vld_op_t                   vop,
    output logic [IDXW-1:0]                    drop_idx,
    // result beat
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               out_hit,
    output logic [lkv_pkg::DIN_W-1:0]          out_read,
    output logic [lkv_pkg::CNT_OUT_W-1:0]      out_count,
    output logic [lkv_pkg::CNT_OUT_W-1:0]      out_evicted,
    output logic [lkv_pkg::TOTAL_W-1:0]        out_access,
    output logic [lkv_pkg::TOTAL_W-1:0]        out_hits
);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CW   = (CNTW > lkv_pkg::CFG_W) ? CNTW : lkv_pkg::CFG_W;
    localparam int TW   = lkv_pkg::TOTAL_W;

    lkv_pkg::state_t             state_reg, state_next;
    lkv_pkg::kind_t              kind_reg, kind_next;
    logic [lkv_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0]      data_reg, data_next;
    logic [CNTW-1:0]             count_reg, count_next;
    logic [CNTW-1:0]             evict_reg, evict_next;
    logic                        hit_reg, hit_next;
    logic [lkv_pkg::DIN_W-1:0]   read_reg, read_next;
    logic [lkv_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [TW-1:0]               gets_reg, gets_next;
    logic [TW-1:0]               hits_reg, hits_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        o_hit_reg, o_hit_next;
    logic [lkv_pkg::DIN_W-1:0]   o_read_reg, o_read_next;
    logic [CNTW-1:0]             o_count_reg, o_count_next;
    logic [CNTW-1:0]             o_evict_reg, o_evict_next;
    logic [TW-1:0]               o_access_reg, o_access_next;
    logic [TW-1:0]               o_hits_reg, o_hits_next;
    logic [CW-1:0]               limit;
    logic [CW-1:0]               count_ext;

    // Clamp the entry limit to 1..CAPACITY
    always_comb begin
        if (max_entries == '0) begin
            limit = CW'(1);
        end else if (CW'(max_entries) > CW'(CAPACITY)) begin
            limit = CW'(CAPACITY);
        end else begin
            limit = CW'(max_entries);
        end
    end

    assign count_ext = CW'(count_reg);

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        data_next     = data_reg;
        count_next    = count_reg;
        evict_next    = evict_reg;
        hit_next      = hit_reg;
        read_next     = read_reg;
        stamp_next    = stamp_reg;
        gets_next     = gets_reg;
        hits_next     = hits_reg;
        o_hit_next    = o_hit_reg;
        o_read_next   = o_read_reg;
        o_count_next  = o_count_reg;
        o_evict_next  = o_evict_reg;
        o_access_next = o_access_reg;
        o_hits_next   = o_hits_reg;
        scan_start    = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = match_idx;
        wr_data       = data_reg;
        vop           = '0;
        drop_idx      = old_idx;

        // Drop the result beat once taken
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = in_kind;
                    key_next   = in_key;
                    data_next  = VALUE_WIDTH'(in_data);
                    evict_next = '0;
                    hit_next   = 1'b0;
                    read_next  = '0;
                    unique case (in_kind)
                        lkv_pkg::KIND_PUT,
                        lkv_pkg::KIND_GET: begin
                            scan_start = 1'b1;
                            state_next = lkv_pkg::ST_SCAN;
                        end
                        lkv_pkg::KIND_CLEAR: begin
                            vop.clear_all = 1'b1;
                            count_next    = '0;
                            gets_next     = '0;
                            hits_next     = '0;
                            state_next    = lkv_pkg::ST_DONE;
                        end
                        lkv_pkg::KIND_TRIM: begin
                            state_next = lkv_pkg::ST_TRIM_CHK;
                        end
                        default: begin
                            state_next = lkv_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Evict one oldest entry per scan while over the limit
            lkv_pkg::ST_TRIM_CHK: begin
                if (count_ext > limit) begin
                    scan_start = 1'b1;
                    state_next = lkv_pkg::ST_SCAN;
                end else begin
                    state_next = lkv_pkg::ST_DONE;
                end
            end

            lkv_pkg::ST_SCAN: begin
                if (scan_done) begin
                    unique case (kind_reg)
                        lkv_pkg::KIND_PUT: begin
                            wr_en      = 1'b1;
                            vop.set    = 1'b1;
                            stamp_next = stamp_reg + 64'd1;
                            if (scan_res.match_found) begin
                                wr_idx = match_idx;
                            end else if (count_ext >= limit) begin
                                // Full: drop the oldest, refill the lower of the first free slot and its slot
                                vop.drop   = 1'b1;
                                evict_next = CNTW'(1);
                                if (scan_res.free_found && (free_idx < old_idx)) begin
                                    wr_idx = free_idx;
                                end else begin
                                    wr_idx = old_idx;
                                end
                            end else begin
                                wr_idx     = free_idx;
                                count_next = count_reg + CNTW'(1);
                            end
                            state_next = lkv_pkg::ST_DONE;
                        end
                        lkv_pkg::KIND_GET: begin
                            if (gets_reg != '1) begin
                                gets_next = gets_reg + TW'(1);
                            end
                            if (scan_res.match_found) begin
                                if (hits_reg != '1) begin
                                    hits_next = hits_reg + TW'(1);
                                end
                                wr_en      = 1'b1;
                                wr_idx     = match_idx;
                                wr_data    = match_data;
                                stamp_next = stamp_reg + 64'd1;
                                hit_next   = 1'b1;
                                read_next  = lkv_pkg::DIN_W'(match_data);
                            end
                            state_next = lkv_pkg::ST_DONE;
                        end
                        lkv_pkg::KIND_TRIM: begin
                            vop.drop   = 1'b1;
                            count_next = count_reg - CNTW'(1);
                            evict_next = evict_reg + CNTW'(1);
                            state_next = lkv_pkg::ST_TRIM_CHK;
                        end
                        default: begin
                            state_next = lkv_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Load the result beat once the output register is free
            lkv_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    o_hit_next    = hit_reg;
                    o_read_next   = read_reg;
                    o_count_next  = count_reg;
                    o_evict_next  = evict_reg;
                    o_access_next = gets_reg;
                    o_hits_next   = hits_reg;
                    state_next    = lkv_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lkv_pkg::ST_IDLE;
            count_reg    <= '0;
            stamp_reg    <= '0;
            gets_reg     <= '0;
            hits_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            stamp_reg    <= stamp_next;
            gets_reg     <= gets_next;
            hits_reg     <= hits_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        data_reg     <= data_next;
        evict_reg    <= evict_next;
        hit_reg      <= hit_next;
        read_reg     <= read_next;
        o_hit_reg    <= o_hit_next;
        o_read_reg   <= o_read_next;
        o_count_reg  <= o_count_next;
        o_evict_reg  <= o_evict_next;
        o_access_reg <= o_access_next;
        o_hits_reg   <= o_hits_next;
    end

    assign s_tready    = (state_reg == lkv_pkg::ST_IDLE);
    assign scan_key    = key_reg;
    assign wr_key      = key_reg;
    assign wr_stamp    = stamp_reg;
    assign m_tvalid    = m_tvalid_reg;
    assign out_hit     = o_hit_reg;
    assign out_read    = o_read_reg;
    assign out_count   = lkv_pkg::CNT_OUT_W'(o_count_reg);
    assign out_evicted = lkv_pkg::CNT_OUT_W'(o_evict_reg);
    assign out_access  = o_access_reg;
    assign out_hits    = o_hits_reg;

endmodule

FILE: rtl/lru_key_value_cache.sv
// LRU key/value cache, fully associative. Put and get each run one scan between
// input beat and result beat: one scan reads one entry per cycle through
// a single memory read port and one shared key/stamp comparator.
// Clear runs no scan; trim runs one scan per evicted entry.
// One item at a time; the next input beat is taken while a result waits.
// Synchronous active-low reset empties the store, zeroes stamps and counters.
module lru_key_value_cache #(
    parameter int CAPACITY    = lkv_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = lkv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: max_entries
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lkv_pkg::CFG_W-1:0]       cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lkv_pkg::S_TDATA_W-1:0]   s_tdata,   // key[63:0], data_value[95:64]
    input  logic [lkv_pkg::S_TUSER_W-1:0]   s_tuser,   // kind[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0], entry_count[36:32], evicted_count[41:37],
    // access_total[73:42], hit_total[105:74], zero fill above
    output logic [lkv_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [lkv_pkg::M_TUSER_W-1:0]   m_tuser    // hit[0]
);
    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [lkv_pkg::CFG_W-1:0]     max_entries_reg;
    logic                          scan_start;
    logic [lkv_pkg::KEY_W-1:0]     scan_key;
    logic                          scan_done;
    lkv_pkg::scan_res_t            scan_res;
    logic [IDXW-1:0]               match_idx;
    logic [VALUE_WIDTH-1:0]        match_data;
    logic [IDXW-1:0]               free_idx;
    logic [IDXW-1:0]               old_idx;
    logic [IDXW-1:0]               rd_idx;
    logic [lkv_pkg::KEY_W-1:0]     rd_key;
    logic [VALUE_WIDTH-1:0]        rd_data;
    logic [lkv_pkg::STAMP_W-1:0]   rd_stamp;
    logic                          wr_en;
    logic [IDXW-1:0]               wr_idx;
    logic [lkv_pkg::KEY_W-1:0]     wr_key;
    logic [VALUE_WIDTH-1:0]        wr_data;
    logic [lkv_pkg::STAMP_W-1:0]   wr_stamp;
    lkv_pkg::vld_op_t              vop;
    logic [IDXW-1:0]               drop_idx;
    logic [CAPACITY-1:0]           valid;
    logic                          out_hit;
    logic [lkv_pkg::DIN_W-1:0]     out_read;
    logic [lkv_pkg::CNT_OUT_W-1:0] out_count;
    logic [lkv_pkg::CNT_OUT_W-1:0] out_evicted;
    logic [lkv_pkg::TOTAL_W-1:0]   out_access;
    logic [lkv_pkg::TOTAL_W-1:0]   out_hits;

    // Configuration register, always ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= lkv_pkg::MAX_ENTRIES_RST;
        end else if (cfg_valid) begin
            max_entries_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    lkv_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_kind     (lkv_pkg::kind_t'(s_tuser)),
        .in_key      (s_tdata[lkv_pkg::KEY_W-1:0]),
        .in_data     (s_tdata[lkv_pkg::KEY_W +: lkv_pkg::DIN_W]),
        .max_entries (max_entries_reg),
        .scan_start  (scan_start),
        .scan_key    (scan_key),
        .scan_done   (scan_done),
        .scan_res    (scan_res),
        .match_idx   (match_idx),
        .match_data  (match_data),
        .free_idx    (free_idx),
        .old_idx     (old_idx),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_key      (wr_key),
        .wr_data     (wr_data),
        .wr_stamp    (wr_stamp),
        .vop         (vop),
        .drop_idx    (drop_idx),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_hit     (out_hit),
        .out_read    (out_read),
        .out_count   (out_count),
        .out_evicted (out_evicted),
        .out_access  (out_access),
        .out_hits    (out_hits)
    );

    lkv_scan #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .key        (scan_key),
        .valid      (valid),
        .rd_idx     (rd_idx),
        .rd_key     (rd_key),
        .rd_data    (rd_data),
        .rd_stamp   (rd_stamp),
        .done       (scan_done),
        .res        (scan_res),
        .match_idx  (match_idx),
        .match_data (match_data),
        .free_idx   (free_idx),
        .old_idx    (old_idx)
    );

    lkv_store #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_key   (rd_key),
        .rd_data  (rd_data),
        .rd_stamp (rd_stamp),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_key   (wr_key),
        .wr_data  (wr_data),
        .wr_stamp (wr_stamp),
        .vop      (vop),
        .drop_idx (drop_idx),
        .valid    (valid)
    );

    // Pack the result beat
    assign m_tdata = {{lkv_pkg::M_PAD_W{1'b0}}, out_hits, out_access,
                      out_evicted, out_count, out_read};
    assign m_tuser = out_hit;

endmodule
